// File: hdl/spcm_pkg.sv
// ----------------------------------------------------------------------------
// spcm_pkg
// Shared types and constants of the shape pair contact manifold block.
// ----------------------------------------------------------------------------
package spcm_pkg;

   // pair kinds
   localparam logic [1:0] KIND_CC = 2'd0;  // circle against circle
   localparam logic [1:0] KIND_BB = 2'd1;  // box against box
   localparam logic [1:0] KIND_CB = 2'd2;  // circle against box, either order

   localparam int SQRT_STEPS = 32;

   localparam logic signed [33:0] SAT_MAX = 34'sh0_7FFF_FFFF;
   localparam logic signed [33:0] SAT_MIN = -34'sh0_8000_0000;

   // side data that travels with a pair through the root and divide units
   typedef struct packed {
      logic [1:0]  kind;
      logic        in_box;
      logic        neg_x;
      logic        neg_y;
      logic [31:0] mag_x;
      logic [31:0] mag_y;
      logic [31:0] rad;
      logic [30:0] zpen;
      logic        box_hit;
      logic        box_x;
      logic        box_pos;
      logic [31:0] box_pen;
      logic        chit;
      logic [31:0] dlen;
   } side_type;

   typedef struct packed {
      logic               hit;
      logic signed [15:0] nx;
      logic signed [15:0] ny;
      logic signed [31:0] pen;
   } result_type;

endpackage

// File: hdl/spcm_req_if.sv
// ----------------------------------------------------------------------------
// spcm_req_if
// Pair channel: two shapes per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface spcm_req_if;
   logic               valid;
   logic               ready;
   logic               a_type;
   logic               b_type;
   logic signed [31:0] a_pos_x;
   logic signed [31:0] a_pos_y;
   logic signed [31:0] b_pos_x;
   logic signed [31:0] b_pos_y;
   logic [30:0]        a_size_x;
   logic [30:0]        a_size_y;
   logic [30:0]        b_size_x;
   logic [30:0]        b_size_y;

   modport source (
      output valid, a_type, b_type, a_pos_x, a_pos_y, b_pos_x, b_pos_y,
             a_size_x, a_size_y, b_size_x, b_size_y,
      input  ready
   );
   modport sink (
      input  valid, a_type, b_type, a_pos_x, a_pos_y, b_pos_x, b_pos_y,
             a_size_x, a_size_y, b_size_x, b_size_y,
      output ready
   );
endinterface

// File: hdl/spcm_rsp_if.sv
// ----------------------------------------------------------------------------
// spcm_rsp_if
// Manifold channel: hit flag, contact normal and penetration per word.
// ----------------------------------------------------------------------------
interface spcm_rsp_if;
   logic               valid;
   logic               ready;
   logic               hit;
   logic signed [15:0] normal_x;
   logic signed [15:0] normal_y;
   logic signed [31:0] penetration;

   modport source (
      output valid, hit, normal_x, normal_y, penetration,
      input  ready
   );
   modport sink (
      input  valid, hit, normal_x, normal_y, penetration,
      output ready
   );
endinterface

// File: hdl/shape_pair_contact_manifold_top.sv
// ----------------------------------------------------------------------------
// shape_pair_contact_manifold_top
// Contact manifold for a pair of 2D circles or axis-aligned boxes.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries one shape pair per word (types, Q16.16 centres and sizes);
//   rsp_if returns one manifold word per pair, in order: hit flag, Q2.14 unit
//   normal from A to B and saturated Q16.16 penetration.
//   One pair is accepted every cycle while req_if.ready is high. A response
//   reaches rsp_if after its pair passes seven setup stages (capture,
//   differences, clamping, squares, sum), a 32-stage square root, a
//   NORMAL_FRAC_BITS + 2 stage divider, then the output buffer.
//   When the receiver stalls, the output buffer takes up to two words; the
//   pipeline freezes only once both are full, and req_if.ready drops with it.
//   A frozen pipeline holds every word in place, nothing is dropped.
//   Reset is synchronous, active high, and clears the valid bits and the
//   output buffer; no pair is in flight afterwards.
// ----------------------------------------------------------------------------
module shape_pair_contact_manifold_top #(
   parameter int NORMAL_FRAC_BITS = 14
) (
   input logic        clock,
   input logic        reset,
   spcm_req_if.sink   req_if,
   spcm_rsp_if.source rsp_if
);
   localparam int NF     = NORMAL_FRAC_BITS;
   localparam int SQ_LAT = spcm_pkg::SQRT_STEPS;
   localparam int DV_LAT = NF + 2;
   localparam int VN     = 7 + SQ_LAT + DV_LAT;

   logic          en;
   logic [VN-1:0] vld_ff;
   logic [1:0]    cnt_ff;

   assign en           = (cnt_ff != 2'd2);
   assign req_if.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[VN-2:0], req_if.valid};
      end
   end

   // stage 0: capture
   logic               at0_ff, bt0_ff;
   logic signed [31:0] ax0_ff, ay0_ff, bx0_ff, by0_ff;
   logic [30:0]        asx0_ff, asy0_ff, bsx0_ff, bsy0_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         at0_ff  <= req_if.a_type;
         bt0_ff  <= req_if.b_type;
         ax0_ff  <= req_if.a_pos_x;
         ay0_ff  <= req_if.a_pos_y;
         bx0_ff  <= req_if.b_pos_x;
         by0_ff  <= req_if.b_pos_y;
         asx0_ff <= req_if.a_size_x;
         asy0_ff <= req_if.a_size_y;
         bsx0_ff <= req_if.b_size_x;
         bsy0_ff <= req_if.b_size_y;
      end
   end

   // stage 1: differences, extents, radii
   logic [1:0]         kind_in;
   logic [1:0]         kind1_ff;
   logic signed [32:0] dx1_ff, dy1_ff;
   logic [29:0]        ex1_ff, ey1_ff;
   logic [31:0]        rad1_ff, wsum1_ff, hsum1_ff;
   logic [30:0]        zpen1_ff;

   always_comb begin
      if (!at0_ff && !bt0_ff) begin
         kind_in = spcm_pkg::KIND_CC;
      end else if (at0_ff && bt0_ff) begin
         kind_in = spcm_pkg::KIND_BB;
      end else begin
         kind_in = spcm_pkg::KIND_CB;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         kind1_ff <= kind_in;
         dx1_ff   <= 33'(bx0_ff) - 33'(ax0_ff);
         dy1_ff   <= 33'(by0_ff) - 33'(ay0_ff);
         ex1_ff   <= at0_ff ? asx0_ff[30:1] : bsx0_ff[30:1];
         ey1_ff   <= at0_ff ? asy0_ff[30:1] : bsy0_ff[30:1];
         wsum1_ff <= 32'(asx0_ff) + 32'(bsx0_ff);
         hsum1_ff <= 32'(asy0_ff) + 32'(bsy0_ff);
         if (kind_in == spcm_pkg::KIND_CC) begin
            rad1_ff  <= 32'(asx0_ff) + 32'(bsx0_ff);
            zpen1_ff <= bsx0_ff;
         end else begin
            rad1_ff  <= 32'(at0_ff ? bsx0_ff : asx0_ff);
            zpen1_ff <= at0_ff ? bsx0_ff : asx0_ff;
         end
      end
   end

   // stage 2: magnitudes and clamp tests
   logic [1:0]         kind2_ff;
   logic signed [32:0] dx2_ff, dy2_ff;
   logic [29:0]        ex2_ff, ey2_ff;
   logic [31:0]        rad2_ff, wsum2_ff, hsum2_ff;
   logic [30:0]        zpen2_ff;
   logic [31:0]        mdx2_ff, mdy2_ff;
   logic               posx2_ff, posy2_ff, gtx2_ff, ltx2_ff, gty2_ff, lty2_ff;
   logic signed [32:0] ex1_s, ey1_s;
   logic signed [32:0] adx_in, ady_in;

   assign ex1_s  = signed'({3'b000, ex1_ff});
   assign ey1_s  = signed'({3'b000, ey1_ff});
   assign adx_in = dx1_ff[32] ? -dx1_ff : dx1_ff;
   assign ady_in = dy1_ff[32] ? -dy1_ff : dy1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         kind2_ff <= kind1_ff;
         dx2_ff   <= dx1_ff;
         dy2_ff   <= dy1_ff;
         ex2_ff   <= ex1_ff;
         ey2_ff   <= ey1_ff;
         rad2_ff  <= rad1_ff;
         wsum2_ff <= wsum1_ff;
         hsum2_ff <= hsum1_ff;
         zpen2_ff <= zpen1_ff;
         mdx2_ff  <= adx_in[31:0];
         mdy2_ff  <= ady_in[31:0];
         posx2_ff <= !dx1_ff[32] && (dx1_ff != '0);
         posy2_ff <= !dy1_ff[32] && (dy1_ff != '0);
         gtx2_ff  <= dx1_ff > ex1_s;
         ltx2_ff  <= dx1_ff < -ex1_s;
         gty2_ff  <= dy1_ff > ey1_s;
         lty2_ff  <= dy1_ff < -ey1_s;
      end
   end

   // stage 3: closest point, offset vector, box overlaps
   logic signed [32:0] ex2_s, ey2_s, cx_in, cy_in;
   logic               inside_in;
   logic [1:0]         kind3_ff;
   logic signed [33:0] vx3_ff, vy3_ff, ox3_ff, oy3_ff;
   logic               inside3_ff, posx3_ff, posy3_ff;
   logic [31:0]        rad3_ff;
   logic [30:0]        zpen3_ff;

   assign ex2_s     = signed'({3'b000, ex2_ff});
   assign ey2_s     = signed'({3'b000, ey2_ff});
   assign inside_in = (kind2_ff == spcm_pkg::KIND_CB)
                      && !gtx2_ff && !ltx2_ff && !gty2_ff && !lty2_ff;

   always_comb begin
      cx_in = gtx2_ff ? ex2_s : (ltx2_ff ? -ex2_s : dx2_ff);
      cy_in = gty2_ff ? ey2_s : (lty2_ff ? -ey2_s : dy2_ff);
      // centre inside the box: snap to the edge of the dominant axis
      if (inside_in) begin
         if (mdx2_ff > mdy2_ff) begin
            cx_in = posx2_ff ? ex2_s : -ex2_s;
         end else begin
            cy_in = posy2_ff ? ey2_s : -ey2_s;
         end
      end
      if (kind2_ff == spcm_pkg::KIND_CC) begin
         cx_in = '0;
         cy_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         kind3_ff   <= kind2_ff;
         vx3_ff     <= 34'(dx2_ff) - 34'(cx_in);
         vy3_ff     <= 34'(dy2_ff) - 34'(cy_in);
         ox3_ff     <= signed'(34'(wsum2_ff)) - signed'({1'b0, mdx2_ff, 1'b0});
         oy3_ff     <= signed'(34'(hsum2_ff)) - signed'({1'b0, mdy2_ff, 1'b0});
         inside3_ff <= inside_in;
         posx3_ff   <= posx2_ff;
         posy3_ff   <= posy2_ff;
         rad3_ff    <= rad2_ff;
         zpen3_ff   <= zpen2_ff;
      end
   end

   // stage 4: magnitudes of the offset, box decision
   logic signed [33:0] avx_in, avy_in, bpen_in;
   logic               bx_in;
   spcm_pkg::side_type side4_ff;

   assign avx_in  = vx3_ff[33] ? -vx3_ff : vx3_ff;
   assign avy_in  = vy3_ff[33] ? -vy3_ff : vy3_ff;
   assign bx_in   = ox3_ff < oy3_ff;
   assign bpen_in = ((bx_in ? ox3_ff : oy3_ff) + 34'sd1) >>> 1;

   always_ff @(posedge clock) begin
      if (en) begin
         side4_ff.kind    <= kind3_ff;
         side4_ff.in_box  <= inside3_ff;
         side4_ff.neg_x   <= vx3_ff[33] ^ inside3_ff;
         side4_ff.neg_y   <= vy3_ff[33] ^ inside3_ff;
         side4_ff.mag_x   <= avx_in[31:0];
         side4_ff.mag_y   <= avy_in[31:0];
         side4_ff.rad     <= rad3_ff;
         side4_ff.zpen    <= zpen3_ff;
         side4_ff.box_hit <= (ox3_ff > 34'sd0) && (oy3_ff > 34'sd0);
         side4_ff.box_x   <= bx_in;
         side4_ff.box_pos <= bx_in ? posx3_ff : posy3_ff;
         side4_ff.box_pen <= bpen_in[31:0];
         side4_ff.chit    <= 1'b0;
         side4_ff.dlen    <= '0;
      end
   end

   // stage 5: squares
   logic [63:0]        sqx5_ff, sqy5_ff, rsq5_ff;
   spcm_pkg::side_type side5_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         sqx5_ff  <= 64'(side4_ff.mag_x) * 64'(side4_ff.mag_x);
         sqy5_ff  <= 64'(side4_ff.mag_y) * 64'(side4_ff.mag_y);
         rsq5_ff  <= 64'(side4_ff.rad) * 64'(side4_ff.rad);
         side5_ff <= side4_ff;
      end
   end

   // stage 6: squared length
   logic [64:0]        len6_ff;
   logic [63:0]        rsq6_ff;
   spcm_pkg::side_type side6_ff;
   spcm_pkg::side_type side6_hit;

   always_ff @(posedge clock) begin
      if (en) begin
         len6_ff  <= 65'(sqx5_ff) + 65'(sqy5_ff);
         rsq6_ff  <= rsq5_ff;
         side6_ff <= side5_ff;
      end
   end

   always_comb begin
      side6_hit      = side6_ff;
      side6_hit.chit = side6_ff.in_box || (!len6_ff[64] && (len6_ff[63:0] <= rsq6_ff));
   end

   // root of the squared length
   logic [31:0]        dlen;
   spcm_pkg::side_type sq_ff [SQ_LAT];

   spcm_isqrt u_isqrt (
      .clock (clock),
      .en    (en),
      .rad   (len6_ff[63:0]),
      .root  (dlen)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff[0] <= side6_hit;
         for (int i = 1; i < SQ_LAT; i++) begin
            sq_ff[i] <= sq_ff[i-1];
         end
      end
   end

   // normal components
   logic [NF:0]        qx, qy;
   spcm_pkg::side_type dv_ff [DV_LAT];
   spcm_pkg::side_type dv_in;

   always_comb begin
      dv_in      = sq_ff[SQ_LAT-1];
      dv_in.dlen = dlen;
   end

   spcm_div #(.NF(NF)) u_div_x (
      .clock (clock),
      .en    (en),
      .mag   (sq_ff[SQ_LAT-1].mag_x),
      .den   (dlen),
      .quo   (qx)
   );

   spcm_div #(.NF(NF)) u_div_y (
      .clock (clock),
      .en    (en),
      .mag   (sq_ff[SQ_LAT-1].mag_y),
      .den   (dlen),
      .quo   (qy)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         dv_ff[0] <= dv_in;
         for (int i = 1; i < DV_LAT; i++) begin
            dv_ff[i] <= dv_ff[i-1];
         end
      end
   end

   // result assembly
   spcm_pkg::side_type sf;
   spcm_pkg::result_type res_in;
   logic signed [31:0] one, sqx, sqy;
   logic signed [33:0] pdiff;

   assign sf    = dv_ff[DV_LAT-1];
   assign one   = 32'sd1 <<< NF;
   assign sqx   = sf.neg_x ? -signed'(32'(qx)) : signed'(32'(qx));
   assign sqy   = sf.neg_y ? -signed'(32'(qy)) : signed'(32'(qy));
   assign pdiff = signed'(34'(sf.rad)) - signed'(34'(sf.dlen));

   always_comb begin
      res_in = '0;
      if (sf.kind == spcm_pkg::KIND_BB) begin
         if (sf.box_hit) begin
            res_in.hit = 1'b1;
            res_in.pen = signed'(sf.box_pen);
            if (sf.box_x) begin
               res_in.nx = sf.box_pos ? one[15:0] : 16'(-one);
            end else begin
               res_in.ny = sf.box_pos ? one[15:0] : 16'(-one);
            end
         end
      end else if (sf.chit) begin
         res_in.hit = 1'b1;
         if (sf.dlen == '0) begin
            res_in.nx  = one[15:0];
            res_in.pen = signed'(32'(sf.zpen));
         end else begin
            res_in.nx = sqx[15:0];
            res_in.ny = sqy[15:0];
            if (pdiff > spcm_pkg::SAT_MAX) begin
               res_in.pen = spcm_pkg::SAT_MAX[31:0];
            end else if (pdiff < spcm_pkg::SAT_MIN) begin
               res_in.pen = spcm_pkg::SAT_MIN[31:0];
            end else begin
               res_in.pen = pdiff[31:0];
            end
         end
      end
   end

   // two-word output buffer, head in ent0
   spcm_pkg::result_type ent0_ff, ent1_ff;
   logic push, pop;

   assign push = en && vld_ff[VN-1];
   assign pop  = rsp_if.valid && rsp_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push && pop) begin
         if (cnt_ff == 2'd1) begin
            ent0_ff <= res_in;
         end else begin
            ent0_ff <= ent1_ff;
            ent1_ff <= res_in;
         end
      end else if (push) begin
         if (cnt_ff == 2'd0) begin
            ent0_ff <= res_in;
         end else begin
            ent1_ff <= res_in;
         end
      end else if (pop) begin
         ent0_ff <= ent1_ff;
      end
   end

   assign rsp_if.valid       = (cnt_ff != 2'd0);
   assign rsp_if.hit         = ent0_ff.hit;
   assign rsp_if.normal_x    = ent0_ff.nx;
   assign rsp_if.normal_y    = ent0_ff.ny;
   assign rsp_if.penetration = ent0_ff.pen;

endmodule

// File: hdl/spcm_isqrt.sv
// ----------------------------------------------------------------------------
// spcm_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module spcm_isqrt (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] rad,
   output logic [31:0] root
);
   localparam int STEPS = spcm_pkg::SQRT_STEPS;

   logic [63:0] rem_ff [STEPS];
   logic [63:0] res_ff [STEPS];
   logic [63:0] rem_in [STEPS];
   logic [63:0] res_in [STEPS];

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
      logic [63:0] rem_prev;
      logic [63:0] res_prev;
      logic [63:0] trial;

      if (k == 0) begin : g_first
         assign rem_prev = rad;
         assign res_prev = '0;
      end else begin : g_rest
         assign rem_prev = rem_ff[k-1];
         assign res_prev = res_ff[k-1];
      end

      assign trial     = res_prev + BIT;
      assign rem_in[k] = (rem_prev >= trial) ? rem_prev - trial : rem_prev;
      assign res_in[k] = (rem_prev >= trial) ? (res_prev >> 1) + BIT : res_prev >> 1;

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in[k];
            res_ff[k] <= res_in[k];
         end
      end
   end

   assign root = res_ff[STEPS-1][31:0];

endmodule

// File: hdl/spcm_div.sv
// ----------------------------------------------------------------------------
// spcm_div
// Pipelined rounded divide for one normal component: (mag<<NF + den/2)/den,
// one quotient bit per stage after a numerator stage.
// ----------------------------------------------------------------------------
module spcm_div #(
   parameter int NF = 14
) (
   input  logic          clock,
   input  logic          en,
   input  logic [31:0]   mag,
   input  logic [31:0]   den,
   output logic [NF:0]   quo
);
   localparam int NQ = NF + 1;
   localparam int NW = 32 + NQ;

   logic [NW-1:0] num_ff;
   logic [31:0]   den0_ff;

   logic [31:0]   rem_ff [NQ];
   logic [NQ-1:0] lo_ff  [NQ];
   logic [NQ-1:0] q_ff   [NQ];
   logic [31:0]   den_ff [NQ];

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff  <= (NW'(mag) << NF) + NW'(den >> 1);
         den0_ff <= den;
      end
   end

   for (genvar k = 0; k < NQ; k++) begin : g_step
      logic [31:0]   rem_prev;
      logic [NQ-1:0] lo_prev;
      logic [NQ-1:0] q_prev;
      logic [31:0]   den_prev;
      logic [32:0]   trial;
      logic          take;

      if (k == 0) begin : g_first
         assign rem_prev = num_ff[NW-1:NQ];
         assign lo_prev  = num_ff[NQ-1:0];
         assign q_prev   = '0;
         assign den_prev = den0_ff;
      end else begin : g_rest
         assign rem_prev = rem_ff[k-1];
         assign lo_prev  = lo_ff[k-1];
         assign q_prev   = q_ff[k-1];
         assign den_prev = den_ff[k-1];
      end

      assign trial = {rem_prev, lo_prev[NQ-1-k]};
      assign take  = trial >= {1'b0, den_prev};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= take ? 32'(trial - {1'b0, den_prev}) : trial[31:0];
            lo_ff[k]  <= lo_prev;
            q_ff[k]   <= {q_prev[NQ-2:0], take};
            den_ff[k] <= den_prev;
         end
      end
   end

   assign quo = q_ff[NQ-1];

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives shape pairs into the contact manifold block and checks every
// manifold word against a behavioral predictor, with random stalls.
// ----------------------------------------------------------------------------
module tb;

   localparam int NFB = 14;
   localparam int LATENCY = 42 + NFB;
   localparam int WATCHDOG = 2000;

   typedef struct {
      bit               a_type;
      bit               b_type;
      logic signed [31:0] ax, ay, bx, by;
      logic [30:0]      asx, asy, bsx, bsy;
   } pair_type;

   logic clock = 0;
   logic reset = 1;
   always #6 clock = ~clock;

   spcm_req_if req_if ();
   spcm_rsp_if rsp_if ();

   shape_pair_contact_manifold_top #(.NORMAL_FRAC_BITS(NFB)) DUT (
      .clock(clock), .reset(reset), .req_if(req_if.sink), .rsp_if(rsp_if.source)
   );

   spcm_pkg::result_type expected_manifolds[$];
   int  errors = 0;
   int  idle_cycles = 0;
   bit  allow_stall = 1;

   function automatic longint unsigned root(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic longint abs64(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic logic signed [31:0] sat(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   function automatic logic signed [15:0] unit_comp(longint c, longint unsigned d);
      longint unsigned q;
      q = ((longint'(abs64(c)) << NFB) + (d >> 1)) / d;
      return c < 0 ? -q[15:0] : q[15:0];
   endfunction

   // squared length with carry out of 64 bits
   function automatic longint unsigned len_sq(longint x, longint y, output bit carry);
      longint unsigned s, t;
      s = abs64(x) * abs64(x);
      t = s + abs64(y) * abs64(y);
      carry = t < s;
      return t;
   endfunction

   function automatic spcm_pkg::result_type circle_box_contact(longint nx, longint ny,
                                                               longint ex, longint ey,
                                                               longint r);
      spcm_pkg::result_type o;
      longint cx, cy, vx, vy;
      longint unsigned s, d;
      bit in_box, carry;
      o = '0;
      cx = nx < -ex ? -ex : (nx > ex ? ex : nx);
      cy = ny < -ey ? -ey : (ny > ey ? ey : ny);
      in_box = (cx == nx) && (cy == ny);
      if (in_box) begin
         if (abs64(nx) > abs64(ny)) cx = nx > 0 ? ex : -ex;
         else cy = ny > 0 ? ey : -ey;
      end
      vx = nx - cx;
      vy = ny - cy;
      s = len_sq(vx, vy, carry);
      if (!in_box && (carry || s > longint'(r) * longint'(r))) return o;
      o.hit = 1;
      d = root(s);
      if (d == 0) begin
         o.nx = 16'sd1 <<< NFB;
         o.pen = sat(r);
         return o;
      end
      if (in_box) begin
         vx = -vx;
         vy = -vy;
      end
      o.nx = unit_comp(vx, d);
      o.ny = unit_comp(vy, d);
      o.pen = sat(r - longint'(d));
      return o;
   endfunction

   function automatic spcm_pkg::result_type predict_manifold(pair_type p);
      spcm_pkg::result_type o;
      longint dx, dy, ox2, oy2;
      longint unsigned s, rr, d;
      bit carry;
      o = '0;
      if (!p.a_type && !p.b_type) begin
         dx = longint'(p.bx) - longint'(p.ax);
         dy = longint'(p.by) - longint'(p.ay);
         s = len_sq(dx, dy, carry);
         rr = longint'(p.asx) + longint'(p.bsx);
         if (!carry && s <= rr * rr) begin
            o.hit = 1;
            d = root(s);
            if (d == 0) begin
               o.nx = 16'sd1 <<< NFB;
               o.pen = sat(longint'(p.bsx));
            end else begin
               o.nx = unit_comp(dx, d);
               o.ny = unit_comp(dy, d);
               o.pen = sat(longint'(rr) - longint'(d));
            end
         end
      end else if (p.a_type && p.b_type) begin
         dx = longint'(p.ax) - longint'(p.bx);
         dy = longint'(p.ay) - longint'(p.by);
         ox2 = longint'(p.asx) + longint'(p.bsx) - 2 * abs64(dx);
         oy2 = longint'(p.asy) + longint'(p.bsy) - 2 * abs64(dy);
         if (ox2 > 0 && oy2 > 0) begin
            o.hit = 1;
            if (ox2 < oy2) begin
               o.nx = dx < 0 ? (16'sd1 <<< NFB) : -(16'sd1 <<< NFB);
               o.pen = sat((ox2 + 1) / 2);
            end else begin
               o.ny = dy < 0 ? (16'sd1 <<< NFB) : -(16'sd1 <<< NFB);
               o.pen = sat((oy2 + 1) / 2);
            end
         end
      end else begin
         dx = longint'(p.bx) - longint'(p.ax);
         dy = longint'(p.by) - longint'(p.ay);
         if (p.a_type)
            o = circle_box_contact(dx, dy, p.asx >> 1, p.asy >> 1, p.bsx);
         else
            o = circle_box_contact(dx, dy, p.bsx >> 1, p.bsy >> 1, p.asx);
      end
      return o;
   endfunction

   initial begin
      req_if.valid = 0;
      req_if.a_type = 0; req_if.b_type = 0;
      req_if.a_pos_x = 0; req_if.a_pos_y = 0; req_if.b_pos_x = 0; req_if.b_pos_y = 0;
      req_if.a_size_x = 0; req_if.a_size_y = 0; req_if.b_size_x = 0; req_if.b_size_y = 0;
      rsp_if.ready = 0;
   end

   task automatic send_pair(pair_type p);
      int gap;
      if (allow_stall && $urandom_range(3) == 0) begin
         gap = $urandom_range(1, 15);
         req_if.valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid <= 1;
      req_if.a_type <= p.a_type;  req_if.b_type <= p.b_type;
      req_if.a_pos_x <= p.ax;     req_if.a_pos_y <= p.ay;
      req_if.b_pos_x <= p.bx;     req_if.b_pos_y <= p.by;
      req_if.a_size_x <= p.asx;   req_if.a_size_y <= p.asy;
      req_if.b_size_x <= p.bsx;   req_if.b_size_y <= p.bsy;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      expected_manifolds.insert(expected_manifolds.size(), predict_manifold(p));
      @(negedge clock);
   endtask

   // receiver stall bursts
   initial begin
      @(negedge clock);
      while (1) begin
         if (allow_stall && $urandom_range(3) == 0) begin
            rsp_if.ready <= 0;
            repeat ($urandom_range(1, 15)) @(negedge clock);
         end else begin
            rsp_if.ready <= 1;
            repeat ($urandom_range(1, 20)) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      spcm_pkg::result_type e;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_manifolds.size() == 0) begin
            $display("%0t: unexpected word hit=%0d nx=%0d ny=%0d pen=%0d", $time,
                     rsp_if.hit, rsp_if.normal_x, rsp_if.normal_y, rsp_if.penetration);
            errors++;
         end else begin
            e = expected_manifolds.pop_front();
            if (rsp_if.hit !== e.hit || rsp_if.normal_x !== e.nx ||
                rsp_if.normal_y !== e.ny || rsp_if.penetration !== e.pen) begin
               $display("%0t: expected hit=%0d nx=%0d ny=%0d pen=%0d, got %0d %0d %0d %0d",
                        $time, e.hit, e.nx, e.ny, e.pen, rsp_if.hit, rsp_if.normal_x,
                        rsp_if.normal_y, rsp_if.penetration);
               errors++;
            end
         end
      end
   end

   // watchdog on lack of progress
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles <= 0;
      else if (!reset)
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("shape_pair_contact_manifold_top verification failed");
         $finish;
      end
   end

   function automatic pair_type make_pair(bit at, bit bt, longint ax, longint ay, longint bx,
                                          longint by, longint asx, longint asy, longint bsx,
                                          longint bsy);
      pair_type p;
      p.a_type = at; p.b_type = bt;
      p.ax = 32'(ax); p.ay = 32'(ay); p.bx = 32'(bx); p.by = 32'(by);
      p.asx = 31'(asx); p.asy = 31'(asy); p.bsx = 31'(bsx); p.bsy = 31'(bsy);
      return p;
   endfunction

   function automatic logic [30:0] rand_size(int scale);
      case ($urandom_range(5))
         0: return 31'($urandom);
         1: return '0;
         2: return 31'h7FFF_FFFF;
         default: return 31'($urandom_range(scale));
      endcase
   endfunction

   function automatic logic signed [31:0] rand_pos(int scale);
      case ($urandom_range(7))
         0: return $urandom;
         1: return 32'sh7FFF_FFFF;
         2: return 32'sh8000_0000;
         default: return int'($urandom_range(2 * scale)) - scale;
      endcase
   endfunction

   task automatic test_directed();
      int one;
      one = 1 << 16;
      // coincident circles
      send_pair(make_pair(0, 0, 0, 0, 0, 0, one, 0, 2 * one, 0));
      // touching circles
      send_pair(make_pair(0, 0, 0, 0, 3 * one, 0, one, 0, 2 * one, 0));
      send_pair(make_pair(0, 0, 0, 0, 3 * one, 1, one, 0, 2 * one, 0));
      send_pair(make_pair(0, 0, -one, one, one, -one, 2 * one, 7, 2 * one, 9));
      // extreme positions and radii
      send_pair(make_pair(0, 0, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
                          32'sh7FFF_FFFF, 31'h7FFF_FFFF, 0, 31'h7FFF_FFFF, 0));
      send_pair(make_pair(0, 0, 5, 5, 5, 5, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                          31'h7FFF_FFFF));
      // box-box: x wins, y wins, tie, touching
      send_pair(make_pair(1, 1, 0, 0, one, 0, 2 * one, 4 * one, 2 * one, 4 * one));
      send_pair(make_pair(1, 1, 0, 0, 0, -one, 4 * one, 2 * one, 4 * one, 2 * one));
      send_pair(make_pair(1, 1, 0, 0, one, one, 3 * one, 3 * one, 3 * one, 3 * one));
      send_pair(make_pair(1, 1, 0, 0, 2 * one, 0, 2 * one, 2 * one, 2 * one, 2 * one));
      send_pair(make_pair(1, 1, 0, 0, 1, 1, 3, 3, 0, 0));
      send_pair(make_pair(1, 1, 32'sh8000_0000, 0, 32'sh7FFF_FFFF, 0, 31'h7FFF_FFFF,
                          31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF));
      // circle-box outside, inside, degenerate box, on edge, either order
      send_pair(make_pair(1, 0, 0, 0, 2 * one, one, 2 * one, 2 * one, 2 * one, 0));
      send_pair(make_pair(0, 1, 0, 0, one, 0, one, 0, 4 * one, 4 * one));
      send_pair(make_pair(0, 1, 0, 0, 0, 0, one, 0, 4 * one, 4 * one));
      send_pair(make_pair(0, 1, 0, 0, 0, 0, one, 0, 0, 0));
      send_pair(make_pair(1, 0, 0, 0, one, 0, 2 * one, 2 * one, 3 * one, 0));
      send_pair(make_pair(0, 1, 0, 0, 0, one, one, 0, 4 * one, 4 * one));
      send_pair(make_pair(1, 0, 0, 0, 9 * one, 0, 2 * one, 2 * one, one, 0));
      send_pair(make_pair(1, 0, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
                          32'sh7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 0));
      send_pair(make_pair(0, 1, 0, 0, 0, 0, 31'h7FFF_FFFF, 0, 31'h7FFF_FFFF,
                          31'h7FFF_FFFF));
   endtask

   task automatic test_random(int count);
      pair_type p;
      int scale;
      for (int i = 0; i < count; i++) begin
         // mostly near pairs so hits dominate, some wide ones for misses
         scale = $urandom_range(3) == 0 ? 32'h3FFF_FFFF : (8 << 16);
         p.a_type = 1'($urandom); p.b_type = 1'($urandom);
         p.ax = rand_pos(scale); p.ay = rand_pos(scale);
         p.bx = rand_pos(scale); p.by = rand_pos(scale);
         if ($urandom_range(7) == 0) begin
            p.bx = p.ax; p.by = p.ay;
         end
         p.asx = rand_size(scale); p.asy = rand_size(scale);
         p.bsx = rand_size(scale); p.bsy = rand_size(scale);
         send_pair(p);
      end
   endtask

   initial begin
      int drain;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      test_directed();
      test_random(1000);
      allow_stall = 0;
      test_random(200);
      req_if.valid <= 0;
      drain = 0;
      while (expected_manifolds.size() != 0 && drain < 10 * LATENCY + WATCHDOG) begin
         @(posedge clock);
         drain++;
      end
      repeat (LATENCY) @(posedge clock);
      if (errors == 0 && expected_manifolds.size() == 0)
         $display("shape_pair_contact_manifold_top verification clean");
      else
         $display("shape_pair_contact_manifold_top verification failed");
      $finish;
   end
endmodule
